// ===== design/qwt_pkg.sv =====
`default_nettype none

package qwt_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int FIELD_WIDTH     = 16;
    localparam int MAX_RESULTS     = 3;

    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_NL     = 8'd10;

    typedef enum logic [1:0] {
        KIND_CHAR   = 2'd0,
        KIND_TERM   = 2'd1,
        KIND_TOTALS = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             char_value;
        logic [FIELD_WIDTH-1:0] store_pos;
        logic                   word_valid;
        logic [FIELD_WIDTH-1:0] word_index;
        logic [FIELD_WIDTH-1:0] word_start;
        logic [FIELD_WIDTH-1:0] word_length;
        logic [FIELD_WIDTH-1:0] char_count;
        logic [FIELD_WIDTH-1:0] word_count;
        logic                   last_result;
    } result_t;

endpackage

`default_nettype wire

// ===== design/qwt_outq.sv =====
`default_nettype none

// Holds the results of one byte and hands them out one transfer at a time.
module qwt_outq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic [1:0]        load_num,
    input  wire qwt_pkg::result_t  load_items [qwt_pkg::MAX_RESULTS],
    input  wire logic              out_stall,
    output logic                   out_valid,
    output qwt_pkg::result_t       head,
    output logic                   free
);

    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    qwt_pkg::result_t  items_reg [qwt_pkg::MAX_RESULTS];
    logic              take;

    assign out_valid = (count_reg != 2'd0);
    assign take      = out_valid && !out_stall;
    assign head      = items_reg[0];
    assign free      = (count_reg == 2'd0) || ((count_reg == 2'd1) && take);

    always_comb
    begin
        if (load)
        begin
            count_next = load_num;
        end
        else if (take)
        begin
            count_next = count_reg - 2'd1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            items_reg <= load_items;
        end
        else if (take)
        begin
            items_reg[0] <= items_reg[1];
            items_reg[1] <= items_reg[2];
        end
    end

endmodule

`default_nettype wire

// ===== design/quoted_word_tokenizer_core.sv =====
`default_nettype none

// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  text_byte, final_byte
// output    out        out_valid/out_stall kind .. last_result (one result per transfer)
//
// A byte is held in the input register, where its whole update is done combinationally and its
// zero to three results are loaded into the result queue as soon as the queue is free.
// A byte's results leave one per transfer through the single output port of the result
// queue, and a byte with results waits in the input register until the queue is free.
// Reset clears the tokenizer state and empties both registers.
// A stalled output holds an input byte that has results in its register and then stalls the input.
module quoted_word_tokenizer_core #(
    parameter int COUNT_WIDTH = qwt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [7:0]                         text_byte,
    input  wire logic                               final_byte,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [1:0]                              kind,
    output logic [7:0]                              char_value,
    output logic [qwt_pkg::FIELD_WIDTH-1:0]         store_pos,
    output logic                                    word_valid,
    output logic [qwt_pkg::FIELD_WIDTH-1:0]         word_index,
    output logic [qwt_pkg::FIELD_WIDTH-1:0]         word_start,
    output logic [qwt_pkg::FIELD_WIDTH-1:0]         word_length,
    output logic [qwt_pkg::FIELD_WIDTH-1:0]         char_count,
    output logic [qwt_pkg::FIELD_WIDTH-1:0]         word_count,
    output logic                                    last_result
);

    localparam int FW = qwt_pkg::FIELD_WIDTH;
    localparam int EW = (COUNT_WIDTH > FW) ? COUNT_WIDTH : FW;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH-1:0] r;
        r = (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
        return r;
    endfunction

    function automatic logic [FW-1:0] to_field(input logic [COUNT_WIDTH-1:0] v);
        logic [EW-1:0] w;
        w = EW'(v);
        return w[FW-1:0];
    endfunction

    logic                    in_full_reg;
    logic [7:0]              byte_reg;
    logic                    fin_reg;

    logic                    in_comment_reg, in_comment_next;
    logic                    in_quote_reg, in_quote_next;
    logic                    quote_dbl_reg, quote_dbl_next;
    logic                    word_open_reg, word_open_next;
    logic [COUNT_WIDTH-1:0]  run_len_reg, run_len_next;
    logic [COUNT_WIDTH-1:0]  pack_pos_reg, pack_pos_next;
    logic [COUNT_WIDTH-1:0]  start_pos_reg, start_pos_next;
    logic [COUNT_WIDTH-1:0]  words_reg, words_next;
    logic [COUNT_WIDTH-1:0]  chars_reg, chars_next;

    qwt_pkg::result_t        res [qwt_pkg::MAX_RESULTS];
    logic [1:0]              res_num;
    logic                    q_free;
    logic                    consume;
    qwt_pkg::result_t        head;

    always_comb
    begin
        logic        skip;
        logic        is_sep;
        logic        qmatch;
        logic [1:0]  k;

        in_comment_next = in_comment_reg;
        in_quote_next   = in_quote_reg;
        quote_dbl_next  = quote_dbl_reg;
        word_open_next  = word_open_reg;
        run_len_next    = run_len_reg;
        pack_pos_next   = pack_pos_reg;
        start_pos_next  = start_pos_reg;
        words_next      = words_reg;
        chars_next      = chars_reg;
        k               = 2'd0;
        skip            = 1'b0;
        for (int i = 0; i < qwt_pkg::MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end

        is_sep = (byte_reg == qwt_pkg::CH_SPACE) || (byte_reg == qwt_pkg::CH_TAB)
              || (byte_reg == qwt_pkg::CH_COMMA) || (byte_reg == qwt_pkg::CH_NL);

        if (!in_comment_next && (byte_reg == qwt_pkg::CH_HASH))
        begin
            in_comment_next = 1'b1;
        end
        else if (!in_comment_next && !in_quote_next
                 && ((byte_reg == qwt_pkg::CH_SQUOTE) || (byte_reg == qwt_pkg::CH_DQUOTE)))
        begin
            in_quote_next  = 1'b1;
            quote_dbl_next = (byte_reg == qwt_pkg::CH_DQUOTE);
            word_open_next = 1'b1;
            run_len_next   = '0;
            start_pos_next = pack_pos_next;
            skip           = 1'b1;
        end

        qmatch = quote_dbl_next ? (byte_reg == qwt_pkg::CH_DQUOTE)
                                : (byte_reg == qwt_pkg::CH_SQUOTE);

        if (!skip)
        begin
            if (in_comment_next)
            begin
                if (byte_reg == qwt_pkg::CH_NL)
                begin
                    in_comment_next = 1'b0;
                end
            end
            else if (in_quote_next)
            begin
                if (qmatch)
                begin
                    res[k].kind        = qwt_pkg::KIND_TERM;
                    res[k].store_pos   = to_field(pack_pos_next);
                    res[k].word_valid  = (run_len_next != '0);
                    res[k].word_index  = (run_len_next != '0) ? to_field(words_next) : '0;
                    res[k].word_start  = to_field(start_pos_next);
                    res[k].word_length = to_field(run_len_next);
                    k = k + 2'd1;
                    if (run_len_next != '0)
                    begin
                        words_next = sat_inc(words_next);
                    end
                    pack_pos_next  = sat_inc(pack_pos_next);
                    in_quote_next  = 1'b0;
                    word_open_next = 1'b0;
                    run_len_next   = '0;
                end
                else
                begin
                    if (byte_reg != qwt_pkg::CH_NL)
                    begin
                        res[k].kind       = qwt_pkg::KIND_CHAR;
                        res[k].char_value = byte_reg;
                        res[k].store_pos  = to_field(pack_pos_next);
                        k = k + 2'd1;
                        chars_next    = sat_inc(chars_next);
                        pack_pos_next = sat_inc(pack_pos_next);
                    end
                    run_len_next = sat_inc(run_len_next);
                end
            end
            else if (!is_sep)
            begin
                res[k].kind       = qwt_pkg::KIND_CHAR;
                res[k].char_value = byte_reg;
                res[k].store_pos  = to_field(pack_pos_next);
                k = k + 2'd1;
                chars_next   = sat_inc(chars_next);
                run_len_next = sat_inc(run_len_next);
                if (!word_open_next)
                begin
                    start_pos_next = pack_pos_next;
                    word_open_next = 1'b1;
                    words_next     = sat_inc(words_next);
                end
                pack_pos_next = sat_inc(pack_pos_next);
            end
            else
            begin
                if (word_open_next && (run_len_next != '0))
                begin
                    res[k].kind        = qwt_pkg::KIND_TERM;
                    res[k].store_pos   = to_field(pack_pos_next);
                    res[k].word_valid  = 1'b1;
                    res[k].word_index  = (words_next != '0)
                                       ? to_field(words_next - COUNT_WIDTH'(1)) : '0;
                    res[k].word_start  = to_field(start_pos_next);
                    res[k].word_length = to_field(run_len_next);
                    k = k + 2'd1;
                    pack_pos_next = sat_inc(pack_pos_next);
                end
                word_open_next = 1'b0;
                run_len_next   = '0;
            end
        end

        if (fin_reg)
        begin
            if (in_quote_next)
            begin
                res[k].kind        = qwt_pkg::KIND_TERM;
                res[k].store_pos   = to_field(pack_pos_next);
                res[k].word_valid  = (run_len_next != '0);
                res[k].word_index  = (run_len_next != '0) ? to_field(words_next) : '0;
                res[k].word_start  = to_field(start_pos_next);
                res[k].word_length = to_field(run_len_next);
                k = k + 2'd1;
                if (run_len_next != '0)
                begin
                    words_next = sat_inc(words_next);
                end
                pack_pos_next = sat_inc(pack_pos_next);
            end
            res[k].kind       = qwt_pkg::KIND_TOTALS;
            res[k].store_pos  = to_field(pack_pos_next);
            res[k].char_count = to_field(chars_next);
            res[k].word_count = to_field(words_next);
            k = k + 2'd1;

            in_comment_next = 1'b0;
            in_quote_next   = 1'b0;
            quote_dbl_next  = 1'b0;
            word_open_next  = 1'b0;
            run_len_next    = '0;
            pack_pos_next   = '0;
            start_pos_next  = '0;
            words_next      = '0;
            chars_next      = '0;
        end

        if (k != 2'd0)
        begin
            res[k - 2'd1].last_result = 1'b1;
        end
        res_num = k;
    end

    assign consume  = in_full_reg && ((res_num == 2'd0) || q_free);
    assign in_stall = in_full_reg && !consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            in_comment_reg <= 1'b0;
            in_quote_reg   <= 1'b0;
            quote_dbl_reg  <= 1'b0;
            word_open_reg  <= 1'b0;
            run_len_reg    <= '0;
            pack_pos_reg   <= '0;
            start_pos_reg  <= '0;
            words_reg      <= '0;
            chars_reg      <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                in_full_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_full_reg <= 1'b0;
            end
            if (consume)
            begin
                in_comment_reg <= in_comment_next;
                in_quote_reg   <= in_quote_next;
                quote_dbl_reg  <= quote_dbl_next;
                word_open_reg  <= word_open_next;
                run_len_reg    <= run_len_next;
                pack_pos_reg   <= pack_pos_next;
                start_pos_reg  <= start_pos_next;
                words_reg      <= words_next;
                chars_reg      <= chars_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= text_byte;
            fin_reg  <= final_byte;
        end
    end

    qwt_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (consume && (res_num != 2'd0)),
        .load_num   (res_num),
        .load_items (res),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .head       (head),
        .free       (q_free)
    );

    assign kind        = head.kind;
    assign char_value  = head.char_value;
    assign store_pos   = head.store_pos;
    assign word_valid  = head.word_valid;
    assign word_index  = head.word_index;
    assign word_start  = head.word_start;
    assign word_length = head.word_length;
    assign char_count  = head.char_count;
    assign word_count  = head.word_count;
    assign last_result = head.last_result;

endmodule

`default_nettype wire
